[src/sbpa_pkg.sv]
// Package for the sparse bivariate polynomial adder.
// Holds the field widths, the operation codes and the command type passed from front to back.
// No dependencies.
package sbpa_pkg;

  localparam int COEF_W = 16;
  localparam int POW_W  = 8;
  localparam int KEY_W  = 2 * POW_W;
  localparam int ENTRY_W = COEF_W + KEY_W;
  localparam int SUM_W  = 24;

  localparam int MAX_TERMS_DEF = 32;

  // Command queue between the front and the back; the depth must be a power of two.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    op_e                      op;
    logic signed [COEF_W-1:0] coef;
    logic [POW_W-1:0]         power_x;
    logic [POW_W-1:0]         power_y;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

[src/sparse_bivariate_poly_add.sv]
// Top level of the sparse bivariate polynomial adder.
// Instantiates sbpa_front, sbpa_queue and sbpa_back; depends on sbpa_pkg.
//
// The block adds two sparse polynomials in x and y. A load beat (operation 0) stores one term of
// the second polynomial in a table of MAX_TERMS entries; loads into a full table are dropped. An
// add beat (operation 1) is one term of the first polynomial: its coefficient is summed with every
// stored term of the same x and y powers, those stored coefficients are cleared, and exactly one
// result beat carries the sum and the powers with is_last set. A flush beat (operation 2) sends
// every stored term whose coefficient is still nonzero, in table order, sets is_last on the final
// one and empties the table; if nothing is left it sends one beat with is_empty and is_last set
// and all other fields zero. Operation 3 is accepted and ignored, and loads give no result.
// The front takes a beat whenever the two-entry command queue has room, so up to two beats
// can wait while the back is busy. In the back an add or a flush scans the term table one
// entry per cycle, since the table has a single read port, except while a flush waits for the
// result channel to take a pending term. The table needs no clearing after reset. table_full_o
// is reserved and always low.
module sparse_bivariate_poly_add #(
  parameter int MAX_TERMS = sbpa_pkg::MAX_TERMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [sbpa_pkg::COEF_W-1:0] coefficient_i,
  input  logic [sbpa_pkg::POW_W-1:0]         power_x_i,
  input  logic [sbpa_pkg::POW_W-1:0]         power_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sbpa_pkg::SUM_W-1:0]  sum_coefficient_o,
  output logic [sbpa_pkg::POW_W-1:0]         out_power_x_o,
  output logic [sbpa_pkg::POW_W-1:0]         out_power_y_o,
  output logic                               is_last_o,
  output logic                               is_empty_o,
  output logic                               table_full_o
);
  import sbpa_pkg::*;

  push_t         push;
  queue_status_t q_status;
  cmd_t          head;
  logic          pop;

  // Front: decodes each beat and drops the unused operation code.
  sbpa_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .coefficient_i (coefficient_i),
    .power_x_i     (power_x_i),
    .power_y_i     (power_y_i),
    .q_status_i    (q_status),
    .push_o        (push)
  );

  // Queue: lets the front keep taking beats while the back scans the table.
  sbpa_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Back: term table, scan sequencer and the output register.
  sbpa_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (head),
    .cmd_valid_i       (q_status.valid),
    .cmd_pop_o         (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sum_coefficient_o (sum_coefficient_o),
    .out_power_x_o     (out_power_x_o),
    .out_power_y_o     (out_power_y_o),
    .is_last_o         (is_last_o),
    .is_empty_o        (is_empty_o)
  );

  assign table_full_o = 1'b0;

endmodule

[src/sbpa_front.sv]
// Front part of the sparse bivariate polynomial adder: accepts input beats and decodes them.
// Depends on sbpa_pkg.
module sbpa_front (
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       operation_i,
  input  logic signed [sbpa_pkg::COEF_W-1:0] coefficient_i,
  input  logic [sbpa_pkg::POW_W-1:0]       power_x_i,
  input  logic [sbpa_pkg::POW_W-1:0]       power_y_i,
  input  sbpa_pkg::queue_status_t          q_status_i,
  output sbpa_pkg::push_t                  push_o
);
  import sbpa_pkg::*;

  op_e  op;
  logic keep;

  assign op         = op_e'(operation_i);
  assign in_ready_o = !q_status_i.full;

  // Unused operation codes are accepted and dropped here so the back never sees them.
  always_comb begin
    unique case (op)
      OP_LOAD, OP_ADD, OP_FLUSH: keep = 1'b1;
      default:                   keep = 1'b0;
    endcase
  end

  assign push_o.push         = in_valid_i && in_ready_o && keep;
  assign push_o.cmd.op       = op;
  assign push_o.cmd.coef     = coefficient_i;
  assign push_o.cmd.power_x  = power_x_i;
  assign push_o.cmd.power_y  = power_y_i;

endmodule

[src/sbpa_queue.sv]
// Short command queue that decouples the front from the back of the polynomial adder.
// Depends on sbpa_pkg.
module sbpa_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sbpa_pkg::push_t         push_i,
  input  logic                    pop_i,
  output sbpa_pkg::cmd_t          head_o,
  output sbpa_pkg::queue_status_t status_o
);
  import sbpa_pkg::*;

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              do_pop;

  assign status_o.valid = (fill_q != '0);
  assign status_o.full  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o         = slots_q[rd_ptr_q];
  assign do_pop         = pop_i && status_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i.push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (push_i.push && !do_pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (!push_i.push && do_pop) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      slots_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

[src/sbpa_back.sv]
// Back part of the polynomial adder: owns the term table and runs loads, adds and flushes.
// Depends on sbpa_pkg.
module sbpa_back #(
  parameter int MAX_TERMS = sbpa_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sbpa_pkg::cmd_t                   cmd_i,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sbpa_pkg::SUM_W-1:0] sum_coefficient_o,
  output logic [sbpa_pkg::POW_W-1:0]       out_power_x_o,
  output logic [sbpa_pkg::POW_W-1:0]       out_power_y_o,
  output logic                             is_last_o,
  output logic                             is_empty_o
);
  import sbpa_pkg::*;

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);

  back_state_e state_q, state_d;

  // Term table: coefficient on top, x power, then y power.
  logic [ENTRY_W-1:0] mem [MAX_TERMS];
  logic [ENTRY_W-1:0] rdata_q;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  idx_q;
  logic [IDX_W-1:0]  eval_idx_q;
  logic              eval_v_q;
  logic              pend_v_q;
  logic [ENTRY_W-1:0] pend_q;
  op_e               op_q;
  logic [KEY_W-1:0]  key_q;
  logic signed [SUM_W-1:0] sum_q;

  logic               out_v_q;
  logic signed [SUM_W-1:0] out_sum_q;
  logic [POW_W-1:0]   out_px_q, out_py_q;
  logic               out_last_q, out_empty_q;

  logic signed [COEF_W-1:0] ent_coef;
  logic signed [COEF_W-1:0] pend_coef;
  logic [KEY_W-1:0]   ent_key;
  logic               key_match, ent_nz, slot_free, more, stall, scan_done;

  logic               mem_we, rd_en;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               emit;
  logic signed [SUM_W-1:0] emit_sum;
  logic [POW_W-1:0]   emit_px, emit_py;
  logic               emit_last, emit_empty;

  assign ent_coef  = rdata_q[ENTRY_W-1:KEY_W];
  assign ent_key   = rdata_q[KEY_W-1:0];
  assign pend_coef = pend_q[ENTRY_W-1:KEY_W];
  assign key_match = (ent_key == key_q);
  assign ent_nz    = (ent_coef != '0);
  assign slot_free = !out_v_q || out_ready_i;
  assign more      = (idx_q < count_q);
  assign scan_done = !eval_v_q && !more;
  // A flush hit with a term already pending needs the output register to move the pending one.
  assign stall     = eval_v_q && (op_q == OP_FLUSH) && ent_nz && pend_v_q && !slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == OP_ADD || cmd_i.op == OP_FLUSH)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = count_q[IDX_W-1:0];
    mem_wdata  = {cmd_i.coef, cmd_i.power_x, cmd_i.power_y};
    rd_en      = 1'b0;
    emit       = 1'b0;
    emit_sum   = sum_q;
    emit_px    = key_q[KEY_W-1:POW_W];
    emit_py    = key_q[POW_W-1:0];
    emit_last  = 1'b1;
    emit_empty = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        if (cmd_valid_i && cmd_i.op == OP_LOAD && count_q < CNT_W'(MAX_TERMS)) begin
          mem_we = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          rd_en = more;
          if (eval_v_q && op_q == OP_ADD && key_match) begin
            mem_we    = 1'b1;
            mem_waddr = eval_idx_q;
            mem_wdata = {{COEF_W{1'b0}}, ent_key};
          end
          if (eval_v_q && op_q == OP_FLUSH && ent_nz && pend_v_q) begin
            emit      = 1'b1;
            emit_sum  = SUM_W'(pend_coef);
            emit_px   = pend_q[KEY_W-1:POW_W];
            emit_py   = pend_q[POW_W-1:0];
            emit_last = 1'b0;
          end
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          emit = 1'b1;
          if (op_q == OP_FLUSH) begin
            if (pend_v_q) begin
              emit_sum = SUM_W'(pend_coef);
              emit_px  = pend_q[KEY_W-1:POW_W];
              emit_py  = pend_q[POW_W-1:0];
            end else begin
              emit_sum   = '0;
              emit_px    = '0;
              emit_py    = '0;
              emit_empty = 1'b1;
            end
          end
        end
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      eval_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          eval_v_q <= 1'b0;
          pend_v_q <= 1'b0;
          if (mem_we) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
        ST_SCAN: begin
          if (!stall) begin
            eval_v_q <= more;
            if (eval_v_q && op_q == OP_FLUSH && ent_nz) begin
              pend_v_q <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (slot_free && op_q == OP_FLUSH) begin
            count_q <= '0;
          end
        end
        default: begin
          eval_v_q <= 1'b0;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      op_q  <= cmd_i.op;
      key_q <= {cmd_i.power_x, cmd_i.power_y};
      sum_q <= SUM_W'(cmd_i.coef);
      idx_q <= '0;
    end
    if (state_q == ST_SCAN && !stall) begin
      if (eval_v_q && op_q == OP_ADD && key_match) begin
        sum_q <= sum_q + SUM_W'(ent_coef);
      end
      if (eval_v_q && op_q == OP_FLUSH && ent_nz) begin
        pend_q <= rdata_q;
      end
      if (more) begin
        eval_idx_q <= idx_q[IDX_W-1:0];
        idx_q      <= idx_q + CNT_W'(1);
      end
    end
    if (emit) begin
      out_sum_q   <= emit_sum;
      out_px_q    <= emit_px;
      out_py_q    <= emit_py;
      out_last_q  <= emit_last;
      out_empty_q <= emit_empty;
    end
  end

  // Term table, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  assign out_valid_o       = out_v_q;
  assign sum_coefficient_o = out_sum_q;
  assign out_power_x_o     = out_px_q;
  assign out_power_y_o     = out_py_q;
  assign is_last_o         = out_last_q;
  assign is_empty_o        = out_empty_q;

endmodule

[sim/tb.sv]
// Testbench for sparse_bivariate_poly_add: directed and random load/add/flush beats.
// Checks every result beat against a cycle-free term-table model kept here.
// Depends on sbpa_pkg and the RTL of sparse_bivariate_poly_add.
`timescale 1ns / 100ps

module tb;
  import sbpa_pkg::*;

  localparam int MAX_TERMS = MAX_TERMS_DEF;
  // Number of trailing beats driven with no idling on either side.
  localparam int CALM_TAIL = 30;
  // Target count of random beats that do real work (ignored beats excluded).
  localparam int RANDOM_BEATS = 110;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POW_W-1:0] px;
    logic [POW_W-1:0] py;
    logic             last;
    logic             empty;
  } out_term_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [1:0]                operation_i = OP_NONE;
  logic signed [COEF_W-1:0]  coefficient_i = '0;
  logic [POW_W-1:0]          power_x_i = '0;
  logic [POW_W-1:0]          power_y_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SUM_W-1:0]   sum_coefficient_o;
  logic [POW_W-1:0]          out_power_x_o;
  logic [POW_W-1:0]          out_power_y_o;
  logic                      is_last_o;
  logic                      is_empty_o;
  logic                      table_full_o;

  always #2 clk_i = ~clk_i;

  sparse_bivariate_poly_add #(
    .MAX_TERMS(MAX_TERMS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .coefficient_i     (coefficient_i),
    .power_x_i         (power_x_i),
    .power_y_i         (power_y_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sum_coefficient_o (sum_coefficient_o),
    .out_power_x_o     (out_power_x_o),
    .out_power_y_o     (out_power_y_o),
    .is_last_o         (is_last_o),
    .is_empty_o        (is_empty_o),
    .table_full_o      (table_full_o)
  );

  // Pending input beats and the result beats they are expected to produce.
  cmd_t      term_ops_q[$];
  out_term_t expected_terms_q[$];
  int        errors = 0;

  // Local copy of the second-polynomial term table.
  logic signed [COEF_W-1:0] tbl_coef [MAX_TERMS];
  logic [POW_W-1:0]         tbl_px   [MAX_TERMS];
  logic [POW_W-1:0]         tbl_py   [MAX_TERMS];
  int                       tbl_cnt = 0;

  function automatic bit calm_tail();
    return term_ops_q.size() < CALM_TAIL;
  endfunction

  function automatic void queue_op(op_e op, int coef, int px, int py);
    cmd_t c;
    c.op      = op;
    c.coef    = COEF_W'(coef);
    c.power_x = POW_W'(px);
    c.power_y = POW_W'(py);
    term_ops_q.push_back(c);
  endfunction

  // Applies one accepted beat to the term table and queues its result beats.
  function automatic void apply_term_op(cmd_t c);
    out_term_t r;
    int        acc;
    int        last_i;
    last_i = -1;
    case (c.op)
      OP_LOAD: begin
        // A load into a full table is silently dropped.
        if (tbl_cnt < MAX_TERMS) begin
          tbl_coef[tbl_cnt] = c.coef;
          tbl_px[tbl_cnt]   = c.power_x;
          tbl_py[tbl_cnt]   = c.power_y;
          tbl_cnt++;
        end
      end
      OP_ADD: begin
        // Every stored term with the same powers is summed in and then cleared.
        acc = int'($signed(c.coef));
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl_px[i] == c.power_x && tbl_py[i] == c.power_y) begin
            acc += int'(tbl_coef[i]);
            tbl_coef[i] = '0;
          end
        end
        r.sum   = SUM_W'(acc);
        r.px    = c.power_x;
        r.py    = c.power_y;
        r.last  = 1'b1;
        r.empty = 1'b0;
        expected_terms_q.push_back(r);
      end
      OP_FLUSH: begin
        for (int i = 0; i < tbl_cnt; i++) begin
          if (tbl_coef[i] != 0) last_i = i;
        end
        if (last_i < 0) begin
          // Nothing nonzero left: one empty marker beat.
          r = '0;
          r.last  = 1'b1;
          r.empty = 1'b1;
          expected_terms_q.push_back(r);
        end else begin
          for (int i = 0; i <= last_i; i++) begin
            if (tbl_coef[i] != 0) begin
              r.sum   = SUM_W'(int'(tbl_coef[i]));
              r.px    = tbl_px[i];
              r.py    = tbl_py[i];
              r.last  = (i == last_i);
              r.empty = 1'b0;
              expected_terms_q.push_back(r);
            end
          end
        end
        tbl_cnt = 0;
      end
      default: ;
    endcase
  endfunction

  // Input driver: valid is held with a stable payload until the beat is taken.
  cmd_t cur_op;
  int   in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) apply_term_op(cur_op);
      if (!(in_valid_i && !in_ready_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (term_ops_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!calm_tail() && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(1, 6) - 1;
          in_valid_i <= 1'b0;
        end else begin
          cur_op = term_ops_q.pop_front();
          operation_i   <= cur_op.op;
          coefficient_i <= cur_op.coef;
          power_x_i     <= cur_op.power_x;
          power_y_i     <= cur_op.power_y;
          in_valid_i    <= 1'b1;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  int        out_gap = 0;
  out_term_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_terms_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result beat: sum %0d x %0d y %0d last %0b empty %0b",
                     sum_coefficient_o, out_power_x_o, out_power_y_o, is_last_o, is_empty_o);
        end else begin
          want = expected_terms_q.pop_front();
          if (sum_coefficient_o !== want.sum || out_power_x_o !== want.px ||
              out_power_y_o !== want.py || is_last_o !== want.last ||
              is_empty_o !== want.empty || table_full_o !== 1'b0) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected sum %0d x %0d y %0d last %0b empty %0b full 0",
                       $signed(want.sum), want.px, want.py, want.last, want.empty);
              $display("          got sum %0d x %0d y %0d last %0b empty %0b full %0b",
                       sum_coefficient_o, out_power_x_o, out_power_y_o, is_last_o,
                       is_empty_o, table_full_o);
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else if (!calm_tail() && $urandom_range(0, 3) == 0) begin
        out_gap = $urandom_range(1, 6) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic int rand_coef();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 0;
    if (r == 1) return -32768;
    if (r == 2) return 32767;
    return int'($signed(COEF_W'($urandom())));
  endfunction

  // Stimulus: directed corner cases first, then random load/add/flush groups.
  initial begin
    int              done;
    int              n_load;
    int              n_add;
    int              key;
    logic [KEY_W-1:0] pool [3];
    logic [KEY_W-1:0] k;

    // Flush of an empty table, then an add that matches nothing.
    queue_op(OP_FLUSH, 0, 0, 0);
    queue_op(OP_ADD, -32768, 255, 255);
    // Extremes, a zero coefficient and duplicate stored powers.
    queue_op(OP_LOAD, 32767, 0, 0);
    queue_op(OP_LOAD, 0, 1, 2);
    queue_op(OP_LOAD, 100, 3, 4);
    queue_op(OP_LOAD, 100, 3, 4);
    queue_op(OP_LOAD, -32768, 255, 255);
    queue_op(OP_ADD, 5, 3, 4);
    // Second add on the same powers sees only cleared entries.
    queue_op(OP_ADD, 1, 3, 4);
    queue_op(OP_ADD, -32768, 255, 255);
    queue_op(OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 255), $urandom_range(0, 255));
    queue_op(OP_FLUSH, 0, 0, 0);
    // Only a zero-coefficient term left: flush reports empty.
    queue_op(OP_LOAD, 0, 7, 7);
    queue_op(OP_FLUSH, 0, 0, 0);
    queue_op(OP_ADD, 32767, 0, 0);
    queue_op(OP_LOAD, 1, 170, 85);
    queue_op(OP_LOAD, -1, 85, 170);
    queue_op(OP_FLUSH, 0, 0, MAX_TERMS);

    // A full table of identical minimum terms plus one dropped load gives the most
    // negative sum; a second full table is flushed for the longest result burst.
    k = KEY_W'($urandom());
    for (int i = 0; i <= MAX_TERMS; i++) queue_op(OP_LOAD, -32768, k[15:8], k[7:0]);
    queue_op(OP_ADD, -32768, k[15:8], k[7:0]);
    queue_op(OP_FLUSH, 0, 0, 0);
    for (int i = 0; i < MAX_TERMS + 2; i++)
      queue_op(OP_LOAD, (i % 2 == 0) ? 32767 : rand_coef(), $urandom_range(0, 255),
               $urandom_range(0, 255));
    queue_op(OP_FLUSH, 0, 0, 0);

    done = 0;
    while (done < RANDOM_BEATS) begin
      for (int j = 0; j < 3; j++) pool[j] = KEY_W'($urandom());
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_TERMS - 6, MAX_TERMS + 2)
                                           : $urandom_range(0, 8);
      n_add  = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) begin
        // Loads and adds interleaved.
        while (n_load + n_add > 0) begin
          if (n_add == 0 || (n_load > 0 && $urandom_range(0, 1) == 0)) begin
            k = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 2)] : KEY_W'($urandom());
            queue_op(OP_LOAD, rand_coef(), k[15:8], k[7:0]);
            n_load--;
          end else begin
            k = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 2)] : KEY_W'($urandom());
            queue_op(OP_ADD, rand_coef(), k[15:8], k[7:0]);
            n_add--;
          end
          done++;
        end
      end else begin
        for (int j = 0; j < n_load; j++) begin
          k = ($urandom_range(0, 4) != 0) ? pool[$urandom_range(0, 2)] : KEY_W'($urandom());
          queue_op(OP_LOAD, rand_coef(), k[15:8], k[7:0]);
        end
        for (int j = 0; j < n_add; j++) begin
          k = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 2)] : KEY_W'($urandom());
          queue_op(OP_ADD, rand_coef(), k[15:8], k[7:0]);
        end
        done += n_load + n_add;
      end
      // Occasional noise: an ignored opcode or a stray flush mid-group.
      key = $urandom_range(0, 5);
      if (key == 0)
        queue_op(OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 255),
                 $urandom_range(0, 255));
      else if (key == 1) begin
        queue_op(OP_FLUSH, $urandom_range(0, 65535), $urandom_range(0, 255),
                 $urandom_range(0, 255));
        done++;
      end
      queue_op(OP_FLUSH, rand_coef(), $urandom_range(0, 255), $urandom_range(0, 255));
      done++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (term_ops_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_terms_q.size() != 0) @(posedge clk_i);
    // Let any stray beat surface after the last expected one.
    repeat (2 * MAX_TERMS + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("[sparse_bivariate_poly_add] OK");
    end else begin
      $display("[sparse_bivariate_poly_add] ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #2000000;
    $display("[sparse_bivariate_poly_add] ERROR");
    $finish;
  end

endmodule
